@@ rtl/rycs_pkg.sv @@
// ----------------------------------------------------------------------------
// rycs_pkg
// Shared types, widths, weights and helpers of the RGB to YCbCr converter.
// ----------------------------------------------------------------------------
package rycs_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int PIX_W          = 8;
    localparam int IDX_W          = 12;
    localparam int MODE_W         = 2;
    localparam int WEIGHT_W       = COEF_FRAC_BITS + 1;
    localparam int PROD_W         = PIX_W + WEIGHT_W;
    localparam int ACC_W          = COEF_FRAC_BITS + 11;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 24;
    localparam int OUT_USER_W     = 2;

    localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

    localparam longint FIX_ONE  = longint'(1) << COEF_FRAC_BITS;
    localparam longint FIX_HALF = longint'(1) << (COEF_FRAC_BITS - 1);

    localparam longint WY_R_L = ((longint'(299000) << COEF_FRAC_BITS) + 500000) / 1000000;
    localparam longint WY_B_L = ((longint'(114000) << COEF_FRAC_BITS) + 500000) / 1000000;
    localparam longint WU_R_L = ((longint'(168736) << COEF_FRAC_BITS) + 500000) / 1000000;
    localparam longint WV_B_L = ((longint'(81312) << COEF_FRAC_BITS) + 500000) / 1000000;

    localparam logic [WEIGHT_W-1:0] WY_R = WEIGHT_W'(WY_R_L);
    localparam logic [WEIGHT_W-1:0] WY_B = WEIGHT_W'(WY_B_L);
    localparam logic [WEIGHT_W-1:0] WY_G = WEIGHT_W'(FIX_ONE - WY_R_L - WY_B_L);
    localparam logic [WEIGHT_W-1:0] WU_R = WEIGHT_W'(WU_R_L);
    localparam logic [WEIGHT_W-1:0] WU_G = WEIGHT_W'(FIX_HALF - WU_R_L);
    localparam logic [WEIGHT_W-1:0] WU_B = WEIGHT_W'(FIX_HALF);
    localparam logic [WEIGHT_W-1:0] WV_B = WEIGHT_W'(WV_B_L);
    localparam logic [WEIGHT_W-1:0] WV_G = WEIGHT_W'(FIX_HALF - WV_B_L);
    localparam logic [WEIGHT_W-1:0] WV_R = WEIGHT_W'(FIX_HALF);

    localparam logic [ACC_W-1:0] FIX_OFFSET = ACC_W'(longint'(128) << COEF_FRAC_BITS);

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_en;

    function automatic logic [PIX_W-1:0] floor_clamp(input logic [ACC_W-1:0] acc);
        logic [ACC_W-COEF_FRAC_BITS-PIX_W-2:0] high;
        logic [PIX_W-1:0]                      res;
        high = acc[ACC_W-2:COEF_FRAC_BITS+PIX_W];
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (|high) begin
            res = '1;
        end else begin
            res = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
        end
        return res;
    endfunction

endpackage

@@ rtl/rycs_csc.sv @@
// ----------------------------------------------------------------------------
// rycs_csc
// Three-stage color math: weight products, signed sums, floor and clamp.
// ----------------------------------------------------------------------------
module rycs_csc import rycs_pkg::*; (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_red,
    output logic [PIX_W-1:0] o_luma,
    output logic [PIX_W-1:0] o_chroma_blue,
    output logic [PIX_W-1:0] o_chroma_red
);

    logic [PROD_W-1:0] r_p_yr, r_p_yg, r_p_yb;
    logic [PROD_W-1:0] r_p_ur, r_p_ug, r_p_ub;
    logic [PROD_W-1:0] r_p_vr, r_p_vg, r_p_vb;
    logic [ACC_W-1:0]  r_acc_y, r_acc_u, r_acc_v;
    logic [ACC_W-1:0]  n_acc_y, n_acc_u, n_acc_v;
    logic [PIX_W-1:0]  r_luma, r_cb, r_cr;

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_p_yr <= PROD_W'(i_red)   * PROD_W'(WY_R);
            r_p_yg <= PROD_W'(i_green) * PROD_W'(WY_G);
            r_p_yb <= PROD_W'(i_blue)  * PROD_W'(WY_B);
            r_p_ur <= PROD_W'(i_red)   * PROD_W'(WU_R);
            r_p_ug <= PROD_W'(i_green) * PROD_W'(WU_G);
            r_p_ub <= PROD_W'(i_blue)  * PROD_W'(WU_B);
            r_p_vr <= PROD_W'(i_red)   * PROD_W'(WV_R);
            r_p_vg <= PROD_W'(i_green) * PROD_W'(WV_G);
            r_p_vb <= PROD_W'(i_blue)  * PROD_W'(WV_B);
        end
    end

    always_comb begin
        n_acc_y = ACC_W'(r_p_yr) + ACC_W'(r_p_yg) + ACC_W'(r_p_yb);
        n_acc_u = FIX_OFFSET + ACC_W'(r_p_ub) - ACC_W'(r_p_ur) - ACC_W'(r_p_ug);
        n_acc_v = FIX_OFFSET + ACC_W'(r_p_vr) - ACC_W'(r_p_vg) - ACC_W'(r_p_vb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_acc_y <= n_acc_y;
            r_acc_u <= n_acc_u;
            r_acc_v <= n_acc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_luma <= floor_clamp(r_acc_y);
            r_cb   <= floor_clamp(r_acc_u);
            r_cr   <= floor_clamp(r_acc_v);
        end
    end

    assign o_luma        = r_luma;
    assign o_chroma_blue = r_cb;
    assign o_chroma_red  = r_cr;

endmodule

@@ rtl/rgb_to_ycbcr_subsampler_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_subsampler_unit
// Full-range BT.601 RGB to YCbCr conversion with chroma keep flags.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and returns one YCbCr beat for it through
// a three-stage pipeline (products, sums, clamp); the output beat sits in
// the last stage register, and a stall on the output freezes only the stages
// that are full, so empty stages keep filling. Sustained rate is one beat
// per clock while the output accepts beats. The sampling mode is taken from
// the configuration channel, which is always ready; write it while no beat is
// in flight. The keep flags follow the mode and the column and row parity.
module rgb_to_ycbcr_subsampler_unit import rycs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MODE_W-1:0]     i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // blue[7:0], green[15:8], red[23:16], row_index[35:24], col_index[47:36]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // blue_kept[0], red_kept[1]
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    logic [MODE_W-1:0] r_mode;
    logic              r_vld1, r_vld2, r_vld3;
    logic              rdy1, rdy2, rdy3;
    t_stage_en         stage_en;
    logic [PIX_W-1:0]  blue, green, red;
    logic              row_even, col_even;
    logic              n_keep_u, n_keep_v;
    logic [1:0]        r_keep1, r_keep2, r_keep3;
    logic [PIX_W-1:0]  luma, cb, cr;

    assign blue     = i_s_axis_tdata[7:0];
    assign green    = i_s_axis_tdata[15:8];
    assign red      = i_s_axis_tdata[23:16];
    assign row_even = ~i_s_axis_tdata[24];
    assign col_even = ~i_s_axis_tdata[36];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_444;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    assign rdy3 = !r_vld3 || i_m_axis_tready;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;

    assign stage_en.en1 = rdy1;
    assign stage_en.en2 = rdy2;
    assign stage_en.en3 = rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_s_axis_tvalid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_comb begin
        case (r_mode)
            MODE_422: begin
                n_keep_u = col_even;
                n_keep_v = col_even;
            end
            MODE_420: begin
                n_keep_u = col_even && row_even;
                n_keep_v = col_even && !row_even;
            end
            default: begin
                n_keep_u = 1'b1;
                n_keep_v = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_keep1 <= {n_keep_v, n_keep_u};
        end
        if (rdy2) begin
            r_keep2 <= r_keep1;
        end
        if (rdy3) begin
            r_keep3 <= r_keep2;
        end
    end

    rycs_csc u_csc (
        .i_clk         (i_clk),
        .i_en          (stage_en),
        .i_blue        (blue),
        .i_green       (green),
        .i_red         (red),
        .o_luma        (luma),
        .o_chroma_blue (cb),
        .o_chroma_red  (cr)
    );

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_vld3;
    assign o_m_axis_tdata  = {cr, cb, luma};
    assign o_m_axis_tuser  = r_keep3;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld1 && r_vld2 && r_vld3 && !i_m_axis_tready))
        else $error("input stalled while pipeline has room");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld1)
        else $error("accepted beat lost at first stage");

    a_stage1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld1 && !r_vld2) |=> r_vld2)
        else $error("first stage did not advance into empty second stage");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
